// ===== rtl/core/rlss_pkg.sv =====
// types, codes and the colour wheel for the led strip serializer
`timescale 1ns / 1ps

package rlss_pkg;

   typedef enum logic [1:0] {
      FN_TICK    = 2'd0,
      FN_SET_RGB = 2'd1,
      FN_SET_GRB = 2'd2,
      FN_FILL    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_LED_COUNT   = 3'd0,
      CSR_SHORT_TICKS = 3'd1,
      CSR_LONG_TICKS  = 3'd2,
      CSR_RESET_TICKS = 3'd3,
      CSR_WHEEL_STEP  = 3'd4
   } csr_type;

   localparam logic [7:0]  WHEEL_MOD   = 8'd255;
   localparam logic [7:0]  WHEEL_SEG1  = 8'd85;
   localparam logic [7:0]  WHEEL_SEG2  = 8'd170;
   localparam logic [4:0]  LAST_BIT    = 5'd23;
   localparam logic [7:0]  SHORT_RST   = 8'd1;
   localparam logic [7:0]  LONG_RST    = 8'd2;
   localparam logic [15:0] GAP_RST     = 16'd600;
   localparam logic [7:0]  STEP_RST    = 8'd3;

   // reduce an 8-bit value modulo 255
   function automatic logic [7:0] mod255(input logic [7:0] v);
      return (v == WHEEL_MOD) ? 8'd0 : v;
   endfunction

   // add two wheel positions, both below 255
   function automatic logic [7:0] wheel_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, WHEEL_MOD}) begin
         s = s - {1'b0, WHEEL_MOD};
      end
      return s[7:0];
   endfunction

   // grb word for a wheel position below 255
   function automatic logic [23:0] wheel(input logic [7:0] pos);
      logic [7:0] w;
      logic [9:0] w3;
      logic [7:0] up;
      logic [7:0] dn;
      logic [23:0] res;
      if (pos < WHEEL_SEG1) begin
         w = pos;
      end else if (pos < WHEEL_SEG2) begin
         w = pos - WHEEL_SEG1;
      end else begin
         w = pos - WHEEL_SEG2;
      end
      w3 = {w, 1'b0} + {2'b00, w};
      up = w3[7:0];
      dn = WHEEL_MOD - up;
      if (pos < WHEEL_SEG1) begin
         res = {dn, up, 8'd0};
      end else if (pos < WHEEL_SEG2) begin
         res = {8'd0, dn, up};
      end else begin
         res = {up, 8'd0, dn};
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/rgb_led_strip_serializer.sv =====
// led strip serializer: pixel memory, wheel fill and bit waveform sequencer
// one request per cycle for ticks and pixel writes unless rsp_tready holds the response back;
// one response per request, given in the cycle after it through the response register
// a wheel fill holds off requests while it writes min(led_count, MAX_LEDS) memory words
// after reset all MAX_LEDS pixel memory words are cleared, requests held off
// synchronous active-high reset; registers return to 0, 1, 2, 600, 3
`timescale 1ns / 1ps

module rgb_led_strip_serializer #(
   parameter int MAX_LEDS = 128
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: pixel_index[7:0], red[15:8], green[23:16], blue[31:24],
   //        grb_word[55:32], wheel_start[63:56]
   input  logic [63:0] req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: line_level[0], accepted[1], busy_res[2], zero[7:3]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int N_W   = $clog2(MAX_LEDS + 1) + 8;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_GAP,
      PH_HIGH,
      PH_LOW
   } phase_type;

   logic [23:0] mem [MAX_LEDS];

   phase_type   phase_ff, phase_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [4:0]  bit_ff, bit_in;
   logic        clr_ff, clr_in;
   logic [IDX_W-1:0] clr_i_ff, clr_i_in;
   logic        fill_ff, fill_in;
   logic [IDX_W-1:0] fill_i_ff, fill_i_in;
   logic [7:0]  pos_ff, pos_in;
   logic        ld_ff, ld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [7:0]  led_count_ff;
   logic [7:0]  short_ff;
   logic [7:0]  long_ff;
   logic [15:0] gap_ff;
   logic [7:0]  step_ff;

   logic [23:0] cur_word_ff, cur_word_in;
   logic [23:0] rd_q_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [23:0]      mem_wd;
   logic [IDX_W-1:0] rd_addr;

   logic [N_W-1:0]   n_eff;
   logic [N_W-1:0]   n_last;
   logic [IDX_W-1:0] ptr_next;
   logic             req_fire;
   logic             cur_bit;
   logic [7:0]       hi_dur;
   logic [7:0]       lo_dur;
   logic [16:0]      ticks_inc;
   logic [N_W-1:0]   idx_ext;
   logic [IDX_W-1:0] idx_clamp;
   logic [23:0]      set_word;
   logic [23:0]      fill_word;
   logic             level;
   logic             accepted;
   logic             done;

   assign n_eff = ({{(N_W-8){1'b0}}, led_count_ff} > N_W'(MAX_LEDS)) ?
                  N_W'(MAX_LEDS) : {{(N_W-8){1'b0}}, led_count_ff};
   assign n_last   = n_eff - 1'b1;
   assign ptr_next = (N_W'(ptr_ff) == N_W'(MAX_LEDS - 1)) ? '0 : ptr_ff + 1'b1;
   assign req_tready = !clr_ff && !fill_ff && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign cur_bit    = cur_word_ff[bit_ff];
   assign hi_dur     = cur_bit ? long_ff : short_ff;
   assign lo_dur     = cur_bit ? short_ff : long_ff;
   assign ticks_inc  = {1'b0, ticks_ff} + 17'd1;
   assign idx_ext    = N_W'(req_tdata[7:0]);
   assign idx_clamp  = (idx_ext >= n_eff) ? n_last[IDX_W-1:0] : idx_ext[IDX_W-1:0];
   assign set_word   = (req_tuser == rlss_pkg::FN_SET_RGB) ?
                       {req_tdata[23:16], req_tdata[15:8], req_tdata[31:24]} :
                       req_tdata[55:32];
   assign fill_word  = rlss_pkg::wheel(pos_ff);

   always_comb begin
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      ptr_in       = ptr_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      clr_i_in     = clr_i_ff;
      fill_in      = fill_ff;
      fill_i_in    = fill_i_ff;
      pos_in       = pos_ff;
      ld_in        = 1'b0;
      cur_word_in  = cur_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_clamp;
      mem_wd       = set_word;
      rd_addr      = ptr_next;
      level        = 1'b0;
      accepted     = 1'b0;
      done         = 1'b0;

      if (ld_ff) begin
         cur_word_in = rd_q_ff;
      end

      if (clr_ff) begin
         mem_we   = 1'b1;
         mem_wa   = clr_i_ff;
         mem_wd   = '0;
         clr_i_in = clr_i_ff + 1'b1;
         if (N_W'(clr_i_ff) == N_W'(MAX_LEDS - 1)) begin
            clr_in = 1'b0;
         end
      end else if (fill_ff) begin
         mem_we    = 1'b1;
         mem_wa    = fill_i_ff;
         mem_wd    = fill_word;
         fill_i_in = fill_i_ff + 1'b1;
         pos_in    = rlss_pkg::wheel_add(pos_ff, rlss_pkg::mod255(step_ff));
         if (fill_i_ff == '0) begin
            cur_word_in = fill_word;
         end
         if (N_W'(fill_i_ff) == n_last) begin
            fill_in = 1'b0;
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (req_tuser == rlss_pkg::FN_TICK) begin
            case (phase_ff)
               PH_GAP: begin
                  if (ticks_inc >= {1'b0, ((gap_ff == '0) ? 16'd1 : gap_ff)}) begin
                     phase_in = PH_HIGH;
                     ticks_in = '0;
                  end else begin
                     ticks_in = ticks_inc[15:0];
                  end
               end
               PH_HIGH: begin
                  level = 1'b1;
                  if (ticks_inc >= {9'd0, ((hi_dur == '0) ? 8'd1 : hi_dur)}) begin
                     phase_in = PH_LOW;
                     ticks_in = '0;
                  end else begin
                     ticks_in = ticks_inc[15:0];
                  end
               end
               PH_LOW: begin
                  if (ticks_inc >= {9'd0, ((lo_dur == '0) ? 8'd1 : lo_dur)}) begin
                     ticks_in = '0;
                     if (bit_ff != '0) begin
                        bit_in   = bit_ff - 1'b1;
                        phase_in = PH_HIGH;
                     end else if (N_W'(ptr_ff) + 1'b1 < n_eff) begin
                        ptr_in      = ptr_next;
                        bit_in      = rlss_pkg::LAST_BIT;
                        phase_in    = PH_HIGH;
                        cur_word_in = rd_q_ff;
                     end else begin
                        phase_in = PH_IDLE;
                        ptr_in   = '0;
                        done     = 1'b1;
                     end
                  end else begin
                     ticks_in = ticks_inc[15:0];
                  end
               end
               default: begin
               end
            endcase
         end else if (phase_ff == PH_IDLE) begin
            accepted = 1'b1;
            if (n_eff != '0) begin
               phase_in = PH_GAP;
               ticks_in = '0;
               ptr_in   = '0;
               bit_in   = rlss_pkg::LAST_BIT;
               if (req_tuser == rlss_pkg::FN_FILL) begin
                  fill_in   = 1'b1;
                  fill_i_in = '0;
                  pos_in    = rlss_pkg::mod255(req_tdata[63:56]);
               end else begin
                  mem_we  = 1'b1;
                  rd_addr = '0;
                  if (idx_clamp == '0) begin
                     cur_word_in = set_word;
                  end else begin
                     ld_in = 1'b1;
                  end
               end
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {phase_in != PH_IDLE, accepted, level};
         rsp_last_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cur_word_ff <= cur_word_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         ptr_ff       <= '0;
         bit_ff       <= '0;
         clr_ff       <= 1'b1;
         clr_i_ff     <= '0;
         fill_ff      <= 1'b0;
         fill_i_ff    <= '0;
         ld_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         led_count_ff <= '0;
         short_ff     <= rlss_pkg::SHORT_RST;
         long_ff      <= rlss_pkg::LONG_RST;
         gap_ff       <= rlss_pkg::GAP_RST;
         step_ff      <= rlss_pkg::STEP_RST;
      end else begin
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         ptr_ff       <= ptr_in;
         bit_ff       <= bit_in;
         clr_ff       <= clr_in;
         clr_i_ff     <= clr_i_in;
         fill_ff      <= fill_in;
         fill_i_ff    <= fill_i_in;
         ld_ff        <= ld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               rlss_pkg::CSR_LED_COUNT:   led_count_ff <= csr_wdata[7:0];
               rlss_pkg::CSR_SHORT_TICKS: short_ff     <= csr_wdata[7:0];
               rlss_pkg::CSR_LONG_TICKS:  long_ff      <= csr_wdata[7:0];
               rlss_pkg::CSR_RESET_TICKS: gap_ff       <= csr_wdata;
               rlss_pkg::CSR_WHEEL_STEP:  step_ff      <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // no request taken while the memory is cleared or filled
   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      (clr_ff || fill_ff) |-> !req_tready)
      else $error("request taken during memory pass");

   // first word is loaded before the gap can end
   a_load_in_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff || ld_ff) |-> phase_ff == PH_GAP)
      else $error("pixel load outside gap");

   // bit counter stays within a pixel
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= rlss_pkg::LAST_BIT)
      else $error("bit counter out of range");

   // frame end returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && done) |=> (phase_ff == PH_IDLE && ptr_ff == '0))
      else $error("frame end without idle");

endmodule
